FILE: hw/rtl/hse_pkg.sv
// Package for the Hermite segment evaluator: widths, types and saturation helpers.
// No dependencies.
package hse_pkg;

	localparam int COEFF_W   = 48;
	localparam int T_FRAC    = 16;
	localparam int DIR_FRAC  = 16;
	localparam int TENS_FRAC = 8;
	localparam int D_W       = 35;              // segment length, integer root bits
	localparam int SQ_W      = 2 * D_W;         // sum of squares, padded to whole digit pairs
	localparam int REM_W     = D_W + 4;
	localparam int TL_W      = 44;              // tangent length
	localparam int MA_W      = (COEFF_W > TL_W ? COEFF_W : TL_W) + 1;
	localparam int MB_W      = 18;
	localparam int MP_W      = MA_W + MB_W;
	localparam int EXT_W     = MP_W + 2;

	localparam logic [16:0] T_ONE = 17'd65536;

	typedef logic signed [COEFF_W-1:0] coef_t;
	typedef logic signed [EXT_W-1:0]   ext_t;
	typedef logic signed [31:0]        word_t;

	function automatic coef_t sat_c(input ext_t v);
		ext_t hi;
		ext_t lo;
		hi = ext_t'({1'b0, {(COEFF_W-1){1'b1}}});
		lo = -hi - ext_t'(1);
		if (v > hi)
			return coef_t'(hi[COEFF_W-1:0]);
		else if (v < lo)
			return coef_t'(lo[COEFF_W-1:0]);
		else
			return coef_t'(v[COEFF_W-1:0]);
	endfunction

	function automatic word_t sat32(input coef_t v);
		coef_t hi;
		coef_t lo;
		hi = coef_t'(32'sh7fffffff);
		lo = coef_t'(32'sh80000000);
		if (v > hi)
			return 32'sh7fffffff;
		else if (v < lo)
			return 32'sh80000000;
		else
			return word_t'(v[31:0]);
	endfunction

endpackage

FILE: hw/rtl/hermite_segment_evaluator.sv
// Cubic Hermite segment evaluator, top level.
// Depends on hse_pkg.
//
// Keeps the two most recently loaded control points and the cubic coefficients of the
// segment between them. The first load request only stores its point; each later one
// rebuilds the segment: 6 partial squares, a 35-step digit-by-digit square root and
// 8 tangent multiplies, all through one shared 49x18 multiplier. An evaluate request
// runs 18 multiplies plus the saturating Horner adds for three axes and the width, or
// returns zeros with status set when fewer than two points are held. in_ready is
// high only while no request is in work; a finished result waits in the output register
// without blocking the next request.
module hermite_segment_evaluator import hse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [17:0] dir_x,
	input  logic signed [17:0] dir_y,
	input  logic signed [17:0] dir_z,
	input  logic signed [15:0] tension,
	input  logic signed [31:0] width,
	input  logic signed [31:0] spread,
	input  logic        [16:0] param_t,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic signed [31:0] curve_x,
	output logic signed [31:0] curve_y,
	output logic signed [31:0] curve_z,
	output logic signed [31:0] slope_x,
	output logic signed [31:0] slope_y,
	output logic signed [31:0] slope_z,
	output logic signed [31:0] curve_width
);

	typedef enum logic [3:0] {
		S_IDLE, S_SQ_MUL, S_SQ_ACC, S_ROOT, S_TEN_MUL, S_TEN_WB,
		S_DIR_MUL, S_DIR_WB, S_WID, S_EVAL, S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] cnt_q;
	logic [2:0] k_q;
	logic [5:0] it_q;
	logic [1:0] grp_q;
	logic [3:0] u_q;

	word_t              pa_q [3];
	word_t              pb_q [3];
	logic signed [17:0] da_q [3];
	logic signed [17:0] db_q [3];
	logic signed [15:0] ta_q, tb_q;
	word_t              wa_q, sa_q, wb_q, sb_q;

	logic [SQ_W-1:0]         sq_q;
	logic [REM_W-1:0]        rem_q;
	logic [D_W-1:0]          root_q;
	logic signed [TL_W-1:0]  tl_q [2];
	ext_t                    q_q;
	coef_t                   coef_q [16];
	logic [16:0]             t_q;
	coef_t                   acc_q;
	ext_t                    m_q;
	logic signed [MP_W-1:0]  prod_q;
	word_t                   wres_q [7];
	logic                    wstat_q;
	logic                    out_valid_q;
	word_t                   ores_q [7];
	logic                    ostat_q;

	logic [1:0]              ax;
	logic signed [32:0]      dv;
	logic [31:0]             mag;
	logic signed [MA_W-1:0]  a_sel;
	logic signed [MB_W-1:0]  b_sel;
	logic [1:0]              csel;
	coef_t                   c_rd;
	ext_t                    mt;
	ext_t                    sh;
	ext_t                    r_v;
	ext_t                    p_v;
	logic [REM_W-1:0]        rem_n;
	logic [REM_W-1:0]        trial;
	logic [SQ_W-1:0]         pw;
	logic [2:0]              vidx;
	word_t                   wa_d, sa_d;
	ext_t                    dw, kk;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = ostat_q;
	assign curve_x   = ores_q[0];
	assign curve_y   = ores_q[1];
	assign curve_z   = ores_q[2];
	assign slope_x   = ores_q[3];
	assign slope_y   = ores_q[4];
	assign slope_z   = ores_q[5];
	assign curve_width = ores_q[6];

	assign ax  = k_q[2:1];
	assign dv  = 33'(pb_q[ax]) - 33'(pa_q[ax]);
	assign mag = dv[32] ? 32'(-dv) : dv[31:0];
	assign mt  = ext_t'(prod_q >>> T_FRAC);
	assign sh  = ext_t'(prod_q >>> DIR_FRAC);
	assign p_v = ext_t'(dv);
	assign r_v = sh - (p_v + p_v) + q_q;
	assign rem_n = {rem_q[REM_W-3:0], sq_q[SQ_W-1 -: 2]};
	assign trial = REM_W'({root_q, 2'b01});
	assign pw    = k_q[0] ? (SQ_W'(prod_q[47:0]) << 16) : SQ_W'(prod_q[47:0]);
	assign vidx  = (grp_q == 2'd3) ? 3'd6 : {1'b0, grp_q};
	assign wa_d  = wa_q;
	assign sa_d  = sa_q;
	assign dw    = ext_t'(wb_q) - ext_t'(wa_d);
	assign kk    = ext_t'(sb_q) - (dw + dw) + ext_t'(sa_d);

	// coefficient read port: one entry per cycle, picked by the evaluation step
	always_comb begin
		case (u_q)
			4'd1, 4'd9:  csel = 2'd2;
			4'd3, 4'd12: csel = 2'd1;
			4'd5:        csel = 2'd0;
			default:     csel = 2'd3;
		endcase
	end
	assign c_rd = coef_q[{grp_q, csel}];

	// shared multiplier operand select
	always_comb begin
		a_sel = '0;
		b_sel = '0;
		case (state_q)
			S_SQ_MUL: begin
				a_sel = signed'(MA_W'({1'b0, mag}));
				b_sel = signed'(MB_W'(k_q[0] ? mag[31:16] : mag[15:0]));
			end
			S_TEN_MUL: begin
				a_sel = signed'(MA_W'({1'b0, root_q}));
				b_sel = k_q[0] ? MB_W'(tb_q) : MB_W'(ta_q);
			end
			S_DIR_MUL: begin
				a_sel = k_q[0] ? MA_W'(tl_q[1]) : MA_W'(tl_q[0]);
				b_sel = k_q[0] ? db_q[ax] : da_q[ax];
			end
			S_EVAL: begin
				a_sel = (u_q == 4'd0 || u_q == 4'd6) ? MA_W'(c_rd) : MA_W'(acc_q);
				b_sel = signed'(MB_W'(t_q));
			end
			default: begin
				a_sel = '0;
				b_sel = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			it_q        <= '0;
			grp_q       <= '0;
			u_q         <= '0;
			out_valid_q <= 1'b0;
			ostat_q     <= 1'b0;
			wstat_q     <= 1'b0;
			for (int i = 0; i < 7; i++) begin
				ores_q[i] <= '0;
				wres_q[i] <= '0;
			end
		end else begin
			prod_q <= a_sel * b_sel;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (!action) begin
							pa_q[0] <= pb_q[0];
							pa_q[1] <= pb_q[1];
							pa_q[2] <= pb_q[2];
							pb_q[0] <= pos_x;
							pb_q[1] <= pos_y;
							pb_q[2] <= pos_z;
							da_q[0] <= db_q[0];
							da_q[1] <= db_q[1];
							da_q[2] <= db_q[2];
							db_q[0] <= dir_x;
							db_q[1] <= dir_y;
							db_q[2] <= dir_z;
							ta_q <= tb_q;
							tb_q <= tension;
							wa_q <= wb_q;
							sa_q <= sb_q;
							wb_q <= width;
							sb_q <= spread;
							if (cnt_q != 2'd2)
								cnt_q <= cnt_q + 2'd1;
							if (cnt_q != 2'd0) begin
								k_q     <= '0;
								sq_q    <= '0;
								state_q <= S_SQ_MUL;
							end
						end else if (cnt_q != 2'd2) begin
							wstat_q <= 1'b1;
							for (int i = 0; i < 7; i++)
								wres_q[i] <= '0;
							state_q <= S_DONE;
						end else begin
							wstat_q <= 1'b0;
							t_q     <= (param_t > T_ONE) ? T_ONE : param_t;
							grp_q   <= '0;
							u_q     <= '0;
							state_q <= S_EVAL;
						end
					end
				end
				S_SQ_MUL: state_q <= S_SQ_ACC;
				S_SQ_ACC: begin
					sq_q <= sq_q + pw;
					if (k_q == 3'd5) begin
						it_q    <= '0;
						rem_q   <= '0;
						root_q  <= '0;
						state_q <= S_ROOT;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= S_SQ_MUL;
					end
				end
				S_ROOT: begin
					// one root digit per cycle, restoring form
					sq_q <= sq_q << 2;
					if (rem_n >= trial) begin
						rem_q  <= rem_n - trial;
						root_q <= {root_q[D_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_n;
						root_q <= {root_q[D_W-2:0], 1'b0};
					end
					if (it_q == 6'(D_W - 1)) begin
						k_q     <= '0;
						state_q <= S_TEN_MUL;
					end else begin
						it_q <= it_q + 6'd1;
					end
				end
				S_TEN_MUL: state_q <= S_TEN_WB;
				S_TEN_WB: begin
					tl_q[k_q[0]] <= TL_W'(prod_q >>> TENS_FRAC);
					if (k_q[0]) begin
						k_q     <= '0;
						state_q <= S_DIR_MUL;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= S_TEN_MUL;
					end
				end
				S_DIR_MUL: state_q <= S_DIR_WB;
				S_DIR_WB: begin
					if (!k_q[0]) begin
						q_q <= sh;
					end else begin
						coef_q[{ax, 2'd0}] <= sat_c(ext_t'(pa_q[ax]));
						coef_q[{ax, 2'd1}] <= sat_c(q_q);
						coef_q[{ax, 2'd2}] <= sat_c(p_v - q_q - r_v);
						coef_q[{ax, 2'd3}] <= sat_c(r_v);
					end
					if (k_q == 3'd5) begin
						state_q <= S_WID;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= S_DIR_MUL;
					end
				end
				S_WID: begin
					coef_q[12] <= sat_c(ext_t'(wa_q));
					coef_q[13] <= sat_c(ext_t'(sa_q));
					coef_q[14] <= sat_c(dw - ext_t'(sa_q) - kk);
					coef_q[15] <= sat_c(kk);
					state_q    <= S_IDLE;
				end
				S_EVAL: begin
					u_q <= u_q + 4'd1;
					case (u_q)
						4'd1, 4'd3: acc_q <= sat_c(ext_t'(c_rd) + mt);
						4'd5: begin
							wres_q[vidx] <= sat32(sat_c(ext_t'(c_rd) + mt));
							if (grp_q == 2'd3)
								state_q <= S_DONE;
						end
						4'd7: begin
							m_q   <= mt;
							acc_q <= sat_c(mt + mt);
						end
						4'd8:  acc_q <= sat_c(ext_t'(acc_q) + m_q);
						4'd9:  m_q   <= ext_t'(sat_c(ext_t'(c_rd) + ext_t'(c_rd)));
						4'd10: acc_q <= sat_c(m_q + ext_t'(acc_q));
						4'd12: begin
							wres_q[3'd3 + {1'b0, grp_q}] <= sat32(sat_c(ext_t'(c_rd) + mt));
							grp_q <= grp_q + 2'd1;
							u_q   <= '0;
						end
						default: ;
					endcase
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						for (int i = 0; i < 7; i++)
							ores_q[i] <= wres_q[i];
						ostat_q     <= wstat_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: tb/hermite_segment_checker.sv
// Result checker for the Hermite segment evaluator: watches the request and result channels,
// predicts every evaluate result and compares it field by field. Depends on hse_pkg.
`timescale 1ns / 1ps
module hermite_segment_checker import hse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               action,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [17:0] dir_x,
	input  logic signed [17:0] dir_y,
	input  logic signed [17:0] dir_z,
	input  logic signed [15:0] tension,
	input  logic signed [31:0] width,
	input  logic signed [31:0] spread,
	input  logic        [16:0] param_t,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               status,
	input  logic signed [31:0] curve_x,
	input  logic signed [31:0] curve_y,
	input  logic signed [31:0] curve_z,
	input  logic signed [31:0] slope_x,
	input  logic signed [31:0] slope_y,
	input  logic signed [31:0] slope_z,
	input  logic signed [31:0] curve_width,
	output int                 fail_count,
	output int                 pending,
	output int                 results_seen
);

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ST_OK    = 1'b0;
	localparam logic ST_SHORT = 1'b1;

	typedef struct packed {
		logic              status;
		logic signed [31:0] cx, cy, cz, sx, sy, sz, cw;
	} sample_t;

	typedef logic signed [127:0] big_t;

	sample_t      expected_q[$];
	int           held_points;
	big_t         pos_a[3], pos_b[3], dir_a[3], dir_b[3];
	big_t         ten_a, ten_b, wid_a, wid_b, spr_a, spr_b;
	big_t         coef[16];

	function automatic big_t floor_div(big_t v, int s);
		return v >>> s;
	endfunction

	function automatic big_t clip_coef(big_t v);
		big_t hi;
		hi = (big_t'(1) <<< (COEFF_W - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic big_t clip_word(big_t v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic big_t isqrt(big_t s);
		big_t r;
		big_t c;
		r = 0;
		for (int b = 34; b >= 0; b--) begin
			c = r | (big_t'(1) <<< b);
			if (c * c <= s) r = c;
		end
		return r;
	endfunction

	task automatic build_segment();
		big_t dv[3];
		big_t len, t1, t2, q, r, k;
		for (int i = 0; i < 3; i++) dv[i] = pos_b[i] - pos_a[i];
		len = isqrt(dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2]);
		t1 = floor_div(ten_a * len, TENS_FRAC);
		t2 = floor_div(ten_b * len, TENS_FRAC);
		for (int i = 0; i < 3; i++) begin
			q = floor_div(t1 * dir_a[i], DIR_FRAC);
			r = floor_div(t2 * dir_b[i], DIR_FRAC) - 2 * dv[i] + q;
			coef[4*i]   = clip_coef(pos_a[i]);
			coef[4*i+1] = clip_coef(q);
			coef[4*i+2] = clip_coef(dv[i] - q - r);
			coef[4*i+3] = clip_coef(r);
		end
		k = spr_b - 2 * (wid_b - wid_a) + spr_a;
		coef[12] = clip_coef(wid_a);
		coef[13] = clip_coef(spr_a);
		coef[14] = clip_coef((wid_b - wid_a) - spr_a - k);
		coef[15] = clip_coef(k);
	endtask

	function automatic big_t scale_t(big_t c, big_t t);
		return floor_div(c * t, T_FRAC);
	endfunction

	function automatic big_t horner_value(int base, big_t t);
		big_t acc;
		acc = coef[base+3];
		acc = clip_coef(coef[base+2] + scale_t(acc, t));
		acc = clip_coef(coef[base+1] + scale_t(acc, t));
		return clip_coef(coef[base] + scale_t(acc, t));
	endfunction

	function automatic big_t horner_slope(int base, big_t t);
		big_t m, inner;
		m = scale_t(coef[base+3], t);
		inner = clip_coef(clip_coef(coef[base+2] * 2) + clip_coef(clip_coef(m * 2) + m));
		return clip_coef(coef[base+1] + scale_t(inner, t));
	endfunction

	task automatic report(string name, logic signed [31:0] exp_v, logic signed [31:0] got_v);
		if (exp_v !== got_v) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch %s: expected %0d got %0d (result %0d)",
					name, exp_v, got_v, results_seen);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sample_t e;
		big_t t;
		if (!arst_n) begin
			held_points = 0;
			expected_q.delete();
			fail_count = 0;
			results_seen = 0;
			ten_a = 0; ten_b = 0; wid_a = 0; wid_b = 0; spr_a = 0; spr_b = 0;
			for (int i = 0; i < 3; i++) begin
				pos_a[i] = 0; pos_b[i] = 0; dir_a[i] = 0; dir_b[i] = 0;
			end
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result, nothing pending");
				end else begin
					e = expected_q.pop_front();
					report("status", 32'(e.status), 32'(status));
					report("curve_x", e.cx, curve_x);
					report("curve_y", e.cy, curve_y);
					report("curve_z", e.cz, curve_z);
					report("slope_x", e.sx, slope_x);
					report("slope_y", e.sy, slope_y);
					report("slope_z", e.sz, slope_z);
					report("curve_width", e.cw, curve_width);
				end
			end
			if (in_valid && in_ready) begin
				if (action == ACT_LOAD) begin
					pos_a = pos_b; dir_a = dir_b;
					pos_b[0] = pos_x; pos_b[1] = pos_y; pos_b[2] = pos_z;
					dir_b[0] = dir_x; dir_b[1] = dir_y; dir_b[2] = dir_z;
					ten_a = ten_b; ten_b = tension;
					wid_a = wid_b; wid_b = width;
					spr_a = spr_b; spr_b = spread;
					if (held_points < 2) held_points = held_points + 1;
					if (held_points >= 2) build_segment();
				end else begin
					e = '0;
					if (held_points < 2) begin
						e.status = ST_SHORT;
					end else begin
						t = (param_t > T_ONE) ? big_t'(T_ONE) : big_t'(param_t);
						e.status = ST_OK;
						e.cx = clip_word(horner_value(0, t));
						e.cy = clip_word(horner_value(4, t));
						e.cz = clip_word(horner_value(8, t));
						e.sx = clip_word(horner_slope(0, t));
						e.sy = clip_word(horner_slope(4, t));
						e.sz = clip_word(horner_slope(8, t));
						e.cw = clip_word(horner_value(12, t));
					end
					expected_q.push_back(e);
				end
			end
			pending = expected_q.size();
		end
	end

	initial pending = 0;

endmodule

FILE: tb/hermite_segment_evaluator_tb.sv
// Testbench top for the Hermite segment evaluator: drives load and evaluate requests
// with random idling and gives the verdict. Depends on hse_pkg and hermite_segment_checker.
`timescale 1ns / 1ps
module hermite_segment_evaluator_tb;
	import hse_pkg::*;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;
	localparam int   RANDOM_ITEMS = 1530;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic action = ACT_LOAD;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [17:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic signed [15:0] tension = '0;
	logic signed [31:0] width = '0, spread = '0;
	logic [16:0] param_t = '0;
	logic out_valid, out_ready = 1'b0, status;
	logic signed [31:0] curve_x, curve_y, curve_z, slope_x, slope_y, slope_z, curve_width;
	int fail_count, pending, results_seen;
	int loads_sent = 0, evals_sent = 0;
	longint cycles = 0;
	bit quiet_tail = 0;
	bit hold_off = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	hermite_segment_evaluator DUT (.*);

	hermite_segment_checker checker_i (.*);

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int burst;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 16);
				out_ready <= 1'b0;
				repeat (burst) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("hermite_segment_evaluator_tb: FAIL");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick32();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom_range(0, 2000000)) - 32'sd1000000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [17:0] pick_dir();
		case ($urandom_range(0, 4))
			0: return 18'sh1ffff;
			1: return 18'sh20000;
			2: return 18'sd65536;
			default: return 18'($urandom);
		endcase
	endfunction

	task automatic send(logic act, logic signed [31:0] px, py, pz,
			logic signed [17:0] dx, dy, dz, logic signed [15:0] tn,
			logic signed [31:0] w, s, logic [16:0] t);
		action <= act; pos_x <= px; pos_y <= py; pos_z <= pz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz; tension <= tn;
		width <= w; spread <= s; param_t <= t; in_valid <= 1'b1;
		do @(posedge clk); while (!(in_ready === 1'b1));
		if (act == ACT_LOAD) loads_sent++; else evals_sent++;
	endtask

	task automatic send_random_load();
		send(ACT_LOAD, pick32(), pick32(), pick32(), pick_dir(), pick_dir(), pick_dir(),
			16'($urandom), pick32(), pick32(), 17'($urandom));
	endtask

	task automatic send_eval(logic [16:0] t);
		send(ACT_EVAL, $urandom, $urandom, $urandom, 18'($urandom), 18'($urandom),
			18'($urandom), 16'($urandom), $urandom, $urandom, t);
	endtask

	task automatic maybe_idle();
		int burst;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			burst = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (burst) @(posedge clk);
		end
	endtask

	initial begin
		int t;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: too few points, then extremes and parameter endpoints
		send_eval(17'd0);
		send(ACT_LOAD, 32'sh7fffffff, 32'sh80000000, 32'sd0, 18'sh1ffff, 18'sh20000, 18'sd0,
			16'sh7fff, 32'sh7fffffff, 32'sh80000000, 17'd0);
		send_eval(17'd65536);
		send(ACT_LOAD, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 18'sh20000, 18'sh1ffff,
			18'sh1ffff, 16'sh8000, 32'sh80000000, 32'sh7fffffff, 17'h1ffff);
		send_eval(17'd0);
		send_eval(17'd65536);
		send_eval(17'h1ffff);
		send_eval(17'd65537);
		send_eval(17'd32768);
		send(ACT_LOAD, 32'sd65536, 32'sd0, 32'sd0, 18'sd65536, 18'sd0, 18'sd0,
			16'sd256, 32'sd65536, 32'sd0, 17'd0);
		send(ACT_LOAD, 32'sd0, 32'sd0, 32'sd0, 18'sd0, 18'sd0, 18'sd0,
			16'sd0, 32'sd0, 32'sd0, 17'd0);
		send_eval(17'd16384);
		send(ACT_LOAD, 32'sd0, 32'sd0, 32'sd0, 18'sd0, 18'sd0, 18'sd0,
			16'sd0, 32'sd0, 32'sd0, 17'd0);
		send_eval(17'd1);

		// long receiver hold-off while requests keep coming
		hold_off = 1;
		for (int i = 0; i < 12; i++)
			if (i % 3 == 0) send_random_load(); else send_eval(17'($urandom_range(0, 65536)));
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - 150) quiet_tail = 1;
			if (i == RANDOM_ITEMS / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			maybe_idle();
			if ($urandom_range(0, 2) == 0) send_random_load();
			else begin
				t = $urandom_range(0, 9);
				send_eval(t == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536)));
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("covered %0d loads and %0d evaluates, %0d results checked",
			loads_sent, evals_sent, results_seen);
		if (fail_count == 0 && pending == 0)
			$display("hermite_segment_evaluator_tb: PASS");
		else
			$display("hermite_segment_evaluator_tb: FAIL");
		$finish;
	end

endmodule
